// File: design/adp_pkg.sv
// Shared types and constants for the argmax dot product stream block.
// Used by every module of the block; depends on nothing.
package adp_pkg;

   localparam int COORD_W     = 16;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int SUM_W       = 36;
   localparam int SCORE_W     = 34;
   localparam int INDEX_W     = 10;
   localparam int CSR_INDEX_W = 4;
   localparam int RSP_DATA_W  = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [INDEX_W-1:0]        index;
      logic                      scored;
      logic                      last;
   } entry_type;

endpackage

// File: design/adp_front.sv
// Front end: weight registers, point counting, products and clamped score.
// Two register stages; depends on adp_pkg.
module adp_front #(
   parameter int DIMENSIONS = 4,
   parameter int MAX_POINTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [adp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [adp_pkg::COORD_W-1:0]           csr_data,
   input  logic                                  in_accept,
   input  logic [DIMENSIONS*adp_pkg::COORD_W-1:0] in_data,
   input  logic                                  in_last,
   output logic                                  out_push,
   output adp_pkg::entry_type                    out_entry,
   output logic [1:0]                            inflight
);
   import adp_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic signed [COORD_W-1:0] weight_ff [DIMENSIONS];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      scored;

   logic                      s1_valid_ff;
   logic signed [PROD_W-1:0]  s1_prod_ff [DIMENSIONS];
   logic [INDEX_W-1:0]        s1_index_ff;
   logic                      s1_scored_ff;
   logic                      s1_last_ff;

   logic                      s2_valid_ff;
   entry_type                 s2_entry_ff, s2_entry_in;
   logic signed [SUM_W-1:0]   sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIMENSIONS; k++) weight_ff[k] <= '0;
      end else if (csr_write) begin
         for (int k = 0; k < DIMENSIONS; k++) begin
            if (csr_index == CSR_INDEX_W'(k)) weight_ff[k] <= csr_data;
         end
      end
   end

   assign scored = (count_ff < CNT_W'(MAX_POINTS));

   always_comb begin
      count_in = count_ff;
      if (in_accept) begin
         if (in_last) begin
            count_in = '0;
         end else if (scored) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= in_accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIMENSIONS; k++) begin
         s1_prod_ff[k] <= $signed(in_data[k*COORD_W +: COORD_W]) * weight_ff[k];
      end
      s1_index_ff  <= INDEX_W'(count_ff);
      s1_scored_ff <= scored;
      s1_last_ff   <= in_last;
      s2_entry_ff  <= s2_entry_in;
   end

   always_comb begin
      sum = '0;
      for (int k = 0; k < DIMENSIONS; k++) begin
         sum = sum + SUM_W'(s1_prod_ff[k]);
      end
      s2_entry_in.index  = s1_index_ff;
      s2_entry_in.scored = s1_scored_ff;
      s2_entry_in.last   = s1_last_ff;
      if (sum > SUM_W'(SCORE_MAX)) begin
         s2_entry_in.score = SCORE_MAX;
      end else if (sum < SUM_W'(SCORE_MIN)) begin
         s2_entry_in.score = SCORE_MIN;
      end else begin
         s2_entry_in.score = SCORE_W'(sum);
      end
   end

   assign out_push  = s2_valid_ff;
   assign out_entry = s2_entry_ff;
   assign inflight  = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};

endmodule

// File: design/adp_queue.sv
// Short queue of point entries between front end and back end.
// Depends on adp_pkg for the entry type and depth.
module adp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  adp_pkg::entry_type          push_entry,
   input  logic                        pop,
   output logic                        head_valid,
   output adp_pkg::entry_type          head_entry,
   output logic [adp_pkg::QCNT_W-1:0]  count
);
   import adp_pkg::*;

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// File: design/adp_back.sv
// Back end: running best compare, saturation tracking and result register.
// Depends on adp_pkg.
module adp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  adp_pkg::entry_type                  head_entry,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [adp_pkg::INDEX_W-1:0]         rsp_index,
   output logic signed [adp_pkg::SCORE_W-1:0]  rsp_score,
   output logic                                rsp_saturated
);
   import adp_pkg::*;

   logic signed [SCORE_W-1:0] best_value_ff;
   logic [INDEX_W-1:0]        best_pos_ff;
   logic                      sat_ff;
   logic                      take;
   logic signed [SCORE_W-1:0] next_value;
   logic [INDEX_W-1:0]        next_pos;
   logic                      next_sat;

   logic                      out_valid_ff, out_valid_in;
   logic signed [SCORE_W-1:0] out_score_ff;
   logic [INDEX_W-1:0]        out_index_ff;
   logic                      out_sat_ff;

   assign pop  = head_valid && (!head_entry.last || !out_valid_ff || rsp_ready);
   assign take = head_entry.scored && (head_entry.score > best_value_ff);

   always_comb begin
      next_value = take ? head_entry.score : best_value_ff;
      next_pos   = take ? head_entry.index : best_pos_ff;
      next_sat   = sat_ff | !head_entry.scored;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop && head_entry.last) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_value_ff <= '0;
         best_pos_ff   <= '0;
         sat_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            if (head_entry.last) begin
               best_value_ff <= '0;
               best_pos_ff   <= '0;
               sat_ff        <= 1'b0;
            end else begin
               best_value_ff <= next_value;
               best_pos_ff   <= next_pos;
               sat_ff        <= next_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_entry.last) begin
         out_score_ff <= next_value;
         out_index_ff <= next_pos;
         out_sat_ff   <= next_sat;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_index     = out_index_ff;
   assign rsp_score     = out_score_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

// File: design/argmax_dot_product_stream.sv
// Argmax of weighted dot products over a stream of points.
// Path: a last point passes s1, s2 and the queue; a result register then drives rsp_tvalid.
// Throughput: one point per cycle when req_tready is high; back-end best compare is the recurrence.
// Reset: synchronous, clears weights, point count, running best and all queued points.
// Depends on adp_pkg, adp_front, adp_queue, adp_back.
module argmax_dot_product_stream #(
   parameter int DIMENSIONS = 4,
   parameter int MAX_POINTS = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [DIMENSIONS*adp_pkg::COORD_W-1:0] req_tdata,   // coord_0 .. coord_N-1
   input  logic                                   req_tlast,   // last_point
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [adp_pkg::RSP_DATA_W-1:0]         rsp_tdata,   // best_index, best_score, zero pad
   output logic                                   rsp_tuser,   // count_saturated
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [adp_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [adp_pkg::COORD_W-1:0]            csr_data
);
   import adp_pkg::*;

   logic                      req_accept;
   logic                      push;
   entry_type                 push_entry;
   logic [1:0]                inflight;
   logic                      pop;
   logic                      head_valid;
   entry_type                 head_entry;
   logic [QCNT_W-1:0]         q_count;
   logic [INDEX_W-1:0]        rsp_index;
   logic signed [SCORE_W-1:0] rsp_score;

   assign csr_ready  = 1'b1;
   assign req_tready = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(inflight))
                       < (QCNT_W+1)'(QUEUE_DEPTH);
   assign req_accept = req_tvalid && req_tready;

   adp_front #(
      .DIMENSIONS (DIMENSIONS),
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_accept (req_accept),
      .in_data   (req_tdata),
      .in_last   (req_tlast),
      .out_push  (push),
      .out_entry (push_entry),
      .inflight  (inflight)
   );

   adp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .count      (q_count)
   );

   adp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_index     (rsp_index),
      .rsp_score     (rsp_score),
      .rsp_saturated (rsp_tuser)
   );

   assign rsp_tdata = {(RSP_DATA_W - SCORE_W - INDEX_W)'(0), rsp_score, rsp_index};

endmodule

// File: design/adp_checker.sv
// Port-level checks for argmax_dot_product_stream, attached by bind.
// Depends on adp_pkg.
module adp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [adp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser
);
   import adp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_score_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[INDEX_W+SCORE_W-1])
      else $error("best score negative");

   a_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[INDEX_W+SCORE_W-1:INDEX_W] == '0)
      |-> (rsp_tdata[INDEX_W-1:0] == '0))
      else $error("nonzero index with zero score");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:INDEX_W+SCORE_W] == '0))
      else $error("pad bits set");

endmodule

bind argmax_dot_product_stream adp_checker u_adp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/tb_argmax_dot_product_stream.sv
// Self-checking testbench for argmax_dot_product_stream: directed rows, then random point sets
// under three sender/receiver stall profiles, checked by an argmax predictor or a typed want.
// Depends on adp_pkg and the argmax_dot_product_stream RTL.
module tb_argmax_dot_product_stream;
   import adp_pkg::*;

   localparam int NUM_COORDS    = 4;
   localparam int POINT_LIMIT   = 1024;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 60;
   localparam int PLAN_ROWS     = 22;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WEIGHT_0 = 4'd0,
      REG_WEIGHT_1 = 4'd1,
      REG_WEIGHT_2 = 4'd2,
      REG_WEIGHT_3 = 4'd3,
      REG_SPARE_LO = 4'd4,
      REG_SPARE_HI = 4'd15
   } weight_reg_type;

   typedef enum logic {ROW_POINT, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [NUM_COORDS-1:0][COORD_W-1:0] coord;
      logic                               last;
   } point_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        index;
      logic signed [SCORE_W-1:0] score;
      logic                      sat;
   } argmax_result_type;

   typedef struct {
      row_kind_type       kind;
      logic [3:0]         reg_index;
      logic [15:0]        reg_value;
      logic [15:0]        c0, c1, c2, c3;
      bit                 last;
      bit                 typed;
      argmax_result_type  want;
   } plan_row_type;

   localparam argmax_result_type ZERO_RESULT = '0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 1, 1, ZERO_RESULT},
      '{ROW_CSR,   REG_WEIGHT_0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_CSR,   REG_WEIGHT_1, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_CSR,   REG_WEIGHT_2, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_CSR,   REG_WEIGHT_3, 16'hF000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_CSR,   REG_SPARE_LO, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_CSR,   REG_SPARE_HI, 16'hABCD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 1, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ZERO_RESULT},
      '{ROW_CSR,   REG_WEIGHT_0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_CSR,   REG_WEIGHT_1, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_CSR,   REG_WEIGHT_2, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_CSR,   REG_WEIGHT_3, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 0, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1, 1, ZERO_RESULT},
      '{ROW_POINT, REG_WEIGHT_0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, ZERO_RESULT}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [NUM_COORDS*COORD_W-1:0]     req_tdata = '0;   // coord_0 .. coord_3
   logic                              req_tlast = 1'b0; // last_point
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]             rsp_tdata;        // best_index, best_score, zero pad
   logic                              rsp_tuser;        // count_saturated
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [CSR_INDEX_W-1:0]            csr_index = '0;
   logic [COORD_W-1:0]                csr_data = '0;

   bit                                req_typed = 1'b0;
   argmax_result_type                 req_want = '0;
   int                                req_idle_pct = 0;
   int                                rsp_idle_pct = 0;
   int                                errors = 0;
   int                                cycle_count = 0;

   logic signed [COORD_W-1:0]         weight_q [NUM_COORDS] = '{default: '0};
   int                                pt_count = 0;
   logic [INDEX_W-1:0]                lead_pos = '0;
   longint                            lead_score = 0;
   bit                                sat_seen = 1'b0;
   argmax_result_type                 best_q [$];

   argmax_dot_product_stream #(
      .DIMENSIONS(NUM_COORDS),
      .MAX_POINTS(POINT_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic bit score_point(input point_type p, output argmax_result_type res);
      longint acc;
      int     k;
      acc = 0;
      res = '0;
      if (pt_count < POINT_LIMIT) begin
         for (k = 0; k < NUM_COORDS; k++)
            acc += longint'($signed(p.coord[k])) * longint'(weight_q[k]);
         if (acc > longint'(SCORE_MAX))
            acc = longint'(SCORE_MAX);
         if (acc < longint'(SCORE_MIN))
            acc = longint'(SCORE_MIN);
         if (acc > lead_score) begin
            lead_score = acc;
            lead_pos   = pt_count[INDEX_W-1:0];
         end
         pt_count++;
      end else begin
         sat_seen = 1'b1;
      end
      if (!p.last)
         return 1'b0;
      res.index  = lead_pos;
      res.score  = lead_score[SCORE_W-1:0];
      res.sat    = sat_seen;
      pt_count   = 0;
      lead_pos   = '0;
      lead_score = 0;
      sat_seen   = 1'b0;
      return 1'b1;
   endfunction

   // predict on every accepted point and register write, then check the response transfer
   always @(posedge clock) begin
      point_type         seen;
      argmax_result_type res;
      argmax_result_type got;
      argmax_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready && csr_index < NUM_COORDS)
            weight_q[csr_index] = $signed(csr_data);
         if (req_tvalid && req_tready) begin
            seen.coord = req_tdata;
            seen.last  = req_tlast;
            if (score_point(seen, res))
               best_q.push_back(req_typed ? req_want : res);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.index = rsp_tdata[INDEX_W-1:0];
            got.score = rsp_tdata[INDEX_W +: SCORE_W];
            got.sat   = rsp_tuser;
            if (best_q.size() == 0) begin
               $display("%0t unexpected result: index %0d score %0d saturated %0b",
                        $time, got.index, got.score, got.sat);
               errors++;
            end else begin
               want = best_q.pop_front();
               if (got.index !== want.index) begin
                  $display("%0t best_index: expected %0d, got %0d", $time, want.index, got.index);
                  errors++;
               end
               if (got.score !== want.score) begin
                  $display("%0t best_score: expected %0d, got %0d", $time, want.score, got.score);
                  errors++;
               end
               if (got.sat !== want.sat) begin
                  $display("%0t count_saturated: expected %0b, got %0b",
                           $time, want.sat, got.sat);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_point(input point_type p, input bit typed, input argmax_result_type want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p.coord;
      req_tlast  <= p.last;
      req_typed  <= typed;
      req_want   <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [COORD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold off the sender until every pending result has been seen, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (best_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_weights(input logic [NUM_COORDS-1:0][COORD_W-1:0] w);
      int k;
      drain();
      for (k = 0; k < NUM_COORDS; k++)
         write_reg(CSR_INDEX_W'(k), w[k]);
      write_reg(CSR_INDEX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom()));
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'(int'($urandom_range(8)) - 4);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [NUM_COORDS-1:0][COORD_W-1:0] pick_vector();
      logic [NUM_COORDS-1:0][COORD_W-1:0] v;
      int                                 k;
      for (k = 0; k < NUM_COORDS; k++)
         v[k] = pick_coord();
      return v;
   endfunction

   task automatic random_sets(input int target);
      point_type p;
      point_type prev;
      int        sent;
      int        len;
      int        i;
      sent = 0;
      prev = '0;
      while (sent < target) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (i = 0; i < len; i++) begin
            // repeat the previous point now and then to produce tied scores
            if (i != 0 && $urandom_range(4) == 0)
               p = prev;
            else
               p.coord = pick_vector();
            p.last = (i == len - 1);
            send_point(p, 1'b0, ZERO_RESULT);
            prev = p;
            sent++;
         end
      end
   endtask

   // overrun the point limit; the strongest point sits at the highest scored index
   task automatic long_set();
      point_type p;
      int        i;
      int        k;
      for (i = 0; i < POINT_LIMIT + 2; i++) begin
         for (k = 0; k < NUM_COORDS; k++)
            p.coord[k] = (i >= POINT_LIMIT - 1) ? 16'h7FFF : 16'($urandom());
         p.last = (i == POINT_LIMIT + 1);
         send_point(p, 1'b0, ZERO_RESULT);
      end
   endtask

   initial begin
      point_type p;
      int        r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 7;
      rsp_idle_pct = 76;
      for (r = 0; r < PLAN_ROWS; r++) begin
         if (plan[r].kind == ROW_CSR) begin
            drain();
            write_reg(plan[r].reg_index, plan[r].reg_value);
         end else begin
            p.coord = {plan[r].c3, plan[r].c2, plan[r].c1, plan[r].c0};
            p.last  = plan[r].last;
            send_point(p, plan[r].typed, plan[r].want);
         end
      end

      load_weights(pick_vector());
      random_sets(PHASE_ITEMS);

      req_idle_pct = 76;
      rsp_idle_pct = 7;
      load_weights({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      random_sets(PHASE_ITEMS / 2);
      load_weights(pick_vector());
      random_sets(PHASE_ITEMS / 2);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      load_weights(pick_vector());
      random_sets(PHASE_ITEMS);
      load_weights({NUM_COORDS{16'h7FFF}});
      long_set();

      drain();
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
design/adp_pkg.sv
design/adp_front.sv
design/adp_queue.sv
design/adp_back.sv
design/argmax_dot_product_stream.sv
design/adp_checker.sv
tb/tb_argmax_dot_product_stream.sv
